### hdl/pnmsp_pkg.sv
// Shared types, codes and helper functions of the netpbm stream parser.
package pnmsp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_DIGIT,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_PIXELS,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    LX_WS,
    LX_COMMENT,
    LX_NUMBER
  } lex_t;

  localparam logic [1:0] FMT_P2 = 2'd0;
  localparam logic [1:0] FMT_P3 = 2'd1;
  localparam logic [1:0] FMT_P5 = 2'd2;
  localparam logic [1:0] FMT_P6 = 2'd3;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_DIGIT  = 3'd1;
  localparam logic [2:0] ERR_ZERO   = 3'd2;
  localparam logic [2:0] ERR_MAXVAL = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;

  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1ffff;
  localparam logic [ACC_W-1:0] MAXVAL_OK = 17'd255;
  localparam logic [ACC_W-1:0] SAMPLE_MAX = 17'd255;

  localparam int unsigned OUT_TDATA_W = 88;

  typedef struct packed {
    logic [1:0]  kind;
    logic        colour;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic [2:0]  err;
    logic        last;
  } result_t;

  function automatic logic text_phase(phase_t ph, logic [1:0] fmt);
    return (ph == PH_WIDTH) || (ph == PH_HEIGHT) || (ph == PH_MAXVAL) ||
           ((ph == PH_PIXELS) && !fmt[1]);
  endfunction

  function automatic result_t err_result(logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    return r;
  endfunction

endpackage

### hdl/pnm_stream_parser_unit.sv
// Top level of the netpbm (P2/P3/P5/P6) byte-stream parser.
// The unit takes one file byte per transfer and can accept a byte in every clock cycle; the
// parser state is updated in the cycle of acceptance and the results are registered in a
// four-entry result queue and offered on the output from its head. A byte yields at most
// two results (the second is always the truncation error on the end-of-file byte), and the
// input is held off only while fewer than two queue entries are free, which happens only
// when the output side stalls or a byte gives two results. out_tuser carries the result
// kind (0 header, 1 pixel, 2 error) and the colour flag; all parser state returns to reset
// after every byte marked with in_tlast, so files may follow one another directly.
module pnm_stream_parser_unit #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // data_byte
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // image_width, image_height, pixel_value, column, row, error_code, zero padding
  output logic [pnmsp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [2:0]                           out_tuser,  // result_kind, is_colour
  output logic                                 out_tlast
);
  import pnmsp_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] push_cnt;
  result_t    push0;
  result_t    push1;
  result_t    head;
  logic       has_room;

  assign in_tready = has_room;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  pnmsp_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_eof   (in_tlast),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (push1)
  );

  pnmsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .pop       (out_fire),
    .head      (head),
    .not_empty (out_tvalid),
    .has_room  (has_room)
  );

  assign out_tdata = {5'd0, head.err, head.row, head.column, head.pixel,
                      head.height, head.width};
  assign out_tuser = {head.colour, head.kind};
  assign out_tlast = head.last;

endmodule

### hdl/pnmsp_parser.sv
// Header lexer, pixel decoder and parser state for one input byte per cycle while the input is not held off.
module pnmsp_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_eof,
  output logic [1:0]          push_cnt,
  output pnmsp_pkg::result_t  push0,
  output pnmsp_pkg::result_t  push1
);
  import pnmsp_pkg::*;

  localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((1 << DIM_BITS) - 1);

  phase_t              phase_r, phase_nxt;
  lex_t                lex_r, lex_nxt;
  logic [1:0]          fmt_r, fmt_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;
  logic [1:0]          chan_r, chan_nxt;

  logic                is_digit;
  logic [ACC_W+3:0]    acc_mul;
  logic [DIM_BITS-1:0] dim_val;
  logic                fin_req;
  logic                smp_req;
  logic [7:0]          smp_val;
  logic                emit_req;
  logic [15:0]         emit_val;
  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS:0]   row_inc;
  logic                last_pix;
  logic                res0_v;
  logic                trunc_v;
  result_t             res0;

  assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {17'd0, in_byte[3:0]};
  assign col_inc  = {1'b0, col_r} + (DIM_BITS+1)'(1);
  assign row_inc  = {1'b0, row_r} + (DIM_BITS+1)'(1);
  assign last_pix = (col_inc == {1'b0, width_r}) && (row_inc == {1'b0, height_r});

  always_comb begin
    phase_nxt  = phase_r;
    lex_nxt    = lex_r;
    fmt_nxt    = fmt_r;
    acc_nxt    = acc_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    chan_nxt   = chan_r;
    dim_val    = '0;
    fin_req    = 1'b0;
    smp_req    = 1'b0;
    smp_val    = in_byte;
    emit_req   = 1'b0;
    emit_val   = '0;
    res0_v     = 1'b0;
    trunc_v    = 1'b0;
    res0       = '0;

    case (phase_r)
      PH_MAGIC: begin
        if (in_byte == CH_P) begin
          phase_nxt = PH_DIGIT;
        end else begin
          res0      = err_result(ERR_MAGIC);
          res0_v    = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_DIGIT: begin
        if (in_byte inside {CH_2, CH_3, CH_5, CH_6}) begin
          case (in_byte)
            CH_2:    fmt_nxt = FMT_P2;
            CH_3:    fmt_nxt = FMT_P3;
            CH_5:    fmt_nxt = FMT_P5;
            default: fmt_nxt = FMT_P6;
          endcase
          phase_nxt = PH_WIDTH;
          lex_nxt   = LX_WS;
          acc_nxt   = '0;
        end else begin
          res0      = err_result(ERR_DIGIT);
          res0_v    = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      default: begin
        if (text_phase(phase_r, fmt_r)) begin
          case (lex_r)
            LX_NUMBER: begin
              if (is_digit) begin
                acc_nxt = (acc_mul > {4'd0, ACC_MAX}) ? ACC_MAX : acc_mul[ACC_W-1:0];
              end else begin
                lex_nxt = (in_byte == CH_HASH) ? LX_COMMENT : LX_WS;
                fin_req = 1'b1;
              end
            end
            LX_COMMENT: begin
              if ((in_byte == CH_LF) || (in_byte == CH_CR)) begin
                lex_nxt = LX_WS;
              end
            end
            default: begin
              if (in_byte == CH_HASH) begin
                lex_nxt = LX_COMMENT;
              end else if (is_digit) begin
                acc_nxt = {13'd0, in_byte[3:0]};
                lex_nxt = LX_NUMBER;
              end
            end
          endcase
        end else if (phase_r == PH_PIXELS) begin
          smp_req = 1'b1;
        end
      end
    endcase

    if (in_eof && text_phase(phase_nxt, fmt_nxt) && (lex_nxt == LX_NUMBER)) begin
      lex_nxt = LX_WS;
      fin_req = 1'b1;
    end

    if (fin_req) begin
      dim_val = (acc_nxt > DIM_MAX) ? DIM_MAX[DIM_BITS-1:0] : acc_nxt[DIM_BITS-1:0];
      case (phase_nxt)
        PH_WIDTH: begin
          width_nxt = dim_val;
          phase_nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_nxt = dim_val;
          if ((width_r == '0) || (dim_val == '0)) begin
            res0      = err_result(ERR_ZERO);
            res0_v    = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_MAXVAL;
          end
        end
        PH_MAXVAL: begin
          if (acc_nxt != MAXVAL_OK) begin
            res0      = err_result(ERR_MAXVAL);
            res0_v    = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            res0.kind   = KIND_HEADER;
            res0.colour = fmt_r[0];
            res0.width  = 16'(width_r);
            res0.height = 16'(height_r);
            res0_v      = 1'b1;
            phase_nxt   = PH_PIXELS;
            col_nxt     = '0;
            row_nxt     = '0;
            chan_nxt    = '0;
          end
        end
        PH_PIXELS: begin
          smp_req = 1'b1;
          smp_val = (acc_nxt > SAMPLE_MAX) ? 8'hff : acc_nxt[7:0];
        end
        default: begin
        end
      endcase
    end

    if (smp_req) begin
      if (!fmt_r[0]) begin
        emit_req = 1'b1;
        emit_val = {8'h00, smp_val};
      end else begin
        case (chan_r)
          2'd0: begin
            red_nxt  = smp_val;
            chan_nxt = 2'd1;
          end
          2'd1: begin
            green_nxt = smp_val;
            chan_nxt  = 2'd2;
          end
          default: begin
            chan_nxt = 2'd0;
            emit_req = 1'b1;
            emit_val = {red_r[7:3], green_r[7:2], smp_val[7:3]};
          end
        endcase
      end
    end

    if (emit_req) begin
      res0.kind   = KIND_PIXEL;
      res0.colour = fmt_r[0];
      res0.width  = 16'(width_r);
      res0.height = 16'(height_r);
      res0.pixel  = emit_val;
      res0.column = 16'(col_r);
      res0.row    = 16'(row_r);
      res0.last   = last_pix;
      res0_v      = 1'b1;
      if (col_inc >= {1'b0, width_r}) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_BITS-1:0];
      end else begin
        col_nxt = col_inc[DIM_BITS-1:0];
      end
      if (last_pix) begin
        phase_nxt = PH_SKIP;
      end
    end

    if (in_eof) begin
      trunc_v    = (phase_nxt != PH_SKIP);
      phase_nxt  = PH_MAGIC;
      lex_nxt    = LX_WS;
      fmt_nxt    = FMT_P2;
      acc_nxt    = '0;
      width_nxt  = '0;
      height_nxt = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      red_nxt    = '0;
      green_nxt  = '0;
      chan_nxt   = '0;
    end
  end

  always_comb begin
    push_cnt = '0;
    if (in_fire) begin
      push_cnt = {1'b0, res0_v} + {1'b0, trunc_v};
    end
    push0 = res0_v ? res0 : err_result(ERR_TRUNC);
    push1 = err_result(ERR_TRUNC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      lex_r    <= LX_WS;
      fmt_r    <= FMT_P2;
      acc_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      red_r    <= '0;
      green_r  <= '0;
      chan_r   <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      lex_r    <= lex_nxt;
      fmt_r    <= fmt_nxt;
      acc_r    <= acc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      chan_r   <= chan_nxt;
    end
  end

endmodule

### hdl/pnmsp_out_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
module pnmsp_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  pnmsp_pkg::result_t push0,
  input  pnmsp_pkg::result_t push1,
  input  logic               pop,
  output pnmsp_pkg::result_t head,
  output logic               not_empty,
  output logic               has_room
);
  import pnmsp_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr_r + PTR_W'(1);
  assign head       = mem_r[rd_ptr_r];
  assign not_empty  = (count_r != '0);
  assign has_room   = (count_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt[PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_ptr_track : assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == rd_ptr_r + count_r[PTR_W-1:0])
    else $error("Result queue pointers disagree with the count.");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> ({1'b0, count_r} + (CNT_W+1)'(push_cnt) <= (CNT_W+1)'(DEPTH)))
    else $error("Result pushed into a full queue.");
`endif

endmodule

### tb/pnm_stream_parser_unit_tb.sv
// Self-checking testbench for the netpbm stream parser: directed and random files with input idling and output stalls.
module pnm_stream_parser_unit_tb;
  import pnmsp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 440;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned live_bytes = 0;
  int unsigned files_sent = 0;
  int unsigned headers_seen = 0;
  int unsigned pixels_seen = 0;
  int unsigned errors_seen = 0;

  // Parser state as the testbench sees it.
  phase_t ph;
  lex_t lex;
  logic [1:0] img_fmt;
  logic [16:0] acc;
  logic [15:0] w_reg;
  logic [15:0] h_reg;
  logic [15:0] col_cnt;
  logic [15:0] row_cnt;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [1:0] chan;

  result_t pending_results[$];
  logic [7:0] file_bytes[$];

  pnm_stream_parser_unit #(.DIM_BITS(16)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  function automatic void parser_clear();
    ph = PH_MAGIC;
    lex = LX_WS;
    img_fmt = FMT_P2;
    acc = '0;
    w_reg = '0;
    h_reg = '0;
    col_cnt = '0;
    row_cnt = '0;
    red_q = '0;
    green_q = '0;
    chan = '0;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic colour, logic [15:0] w,
                                       logic [15:0] h, logic [15:0] pix, logic [15:0] c,
                                       logic [15:0] r, logic [2:0] code, logic last);
    result_t e;
    e.kind = kind;
    e.colour = colour;
    e.width = w;
    e.height = h;
    e.pixel = pix;
    e.column = c;
    e.row = r;
    e.err = code;
    e.last = last;
    pending_results.push_back(e);
  endfunction

  function automatic void raise_fault(logic [2:0] code);
    queue_result(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, code, 1'b0);
    ph = PH_SKIP;
  endfunction

  function automatic void emit_pixel(logic [15:0] value);
    logic last;
    last = ({1'b0, col_cnt} + 17'd1 == {1'b0, w_reg}) &&
           ({1'b0, row_cnt} + 17'd1 == {1'b0, h_reg});
    queue_result(KIND_PIXEL, img_fmt[0], w_reg, h_reg, value, col_cnt, row_cnt, '0, last);
    col_cnt = col_cnt + 16'd1;
    if (col_cnt >= w_reg) begin
      col_cnt = '0;
      row_cnt = row_cnt + 16'd1;
    end
    if (last) ph = PH_SKIP;
  endfunction

  function automatic void take_sample(logic [7:0] s);
    if (!img_fmt[0]) begin
      emit_pixel({8'd0, s});
    end else if (chan == 2'd0) begin
      red_q = s;
      chan = 2'd1;
    end else if (chan == 2'd1) begin
      green_q = s;
      chan = 2'd2;
    end else begin
      chan = 2'd0;
      emit_pixel({red_q[7:3], green_q[7:2], s[7:3]});
    end
  endfunction

  function automatic void finish_number(logic [16:0] v);
    logic [15:0] d;
    d = (v > 17'hffff) ? 16'hffff : v[15:0];
    case (ph)
      PH_WIDTH: begin
        w_reg = d;
        ph = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        h_reg = d;
        if (w_reg == 16'd0 || h_reg == 16'd0) raise_fault(ERR_ZERO);
        else ph = PH_MAXVAL;
      end
      PH_MAXVAL: begin
        if (v != 17'd255) begin
          raise_fault(ERR_MAXVAL);
        end else begin
          queue_result(KIND_HEADER, img_fmt[0], w_reg, h_reg, '0, '0, '0, '0, 1'b0);
          ph = PH_PIXELS;
          col_cnt = '0;
          row_cnt = '0;
          chan = '0;
        end
      end
      PH_PIXELS: take_sample((v > 17'd255) ? 8'hff : v[7:0]);
      default: ;
    endcase
  endfunction

  function automatic logic in_text_field();
    return ph == PH_WIDTH || ph == PH_HEIGHT || ph == PH_MAXVAL ||
           (ph == PH_PIXELS && !img_fmt[1]);
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic digit;
    int unsigned t;
    digit = b >= CH_0 && b <= CH_9;
    if (ph != PH_SKIP) live_bytes++;
    if (ph == PH_MAGIC) begin
      if (b == CH_P) ph = PH_DIGIT;
      else raise_fault(ERR_MAGIC);
    end else if (ph == PH_DIGIT) begin
      if (b == CH_2 || b == CH_3 || b == CH_5 || b == CH_6) begin
        img_fmt = (b == CH_2) ? FMT_P2 : (b == CH_3) ? FMT_P3 : (b == CH_5) ? FMT_P5 : FMT_P6;
        ph = PH_WIDTH;
        lex = LX_WS;
        acc = '0;
      end else begin
        raise_fault(ERR_DIGIT);
      end
    end else if (in_text_field()) begin
      if (lex == LX_NUMBER) begin
        if (digit) begin
          t = 32'(acc);
          t = t * 10 + 32'(b - CH_0);
          acc = (t > 32'h1ffff) ? 17'h1ffff : t[16:0];
        end else begin
          lex = (b == CH_HASH) ? LX_COMMENT : LX_WS;
          finish_number(acc);
        end
      end else if (lex == LX_COMMENT) begin
        if (b == CH_LF || b == CH_CR) lex = LX_WS;
      end else begin
        if (b == CH_HASH) begin
          lex = LX_COMMENT;
        end else if (digit) begin
          acc = {9'd0, b - CH_0};
          lex = LX_NUMBER;
        end
      end
    end else if (ph == PH_PIXELS) begin
      take_sample(b);
    end
    if (eof) begin
      if (in_text_field() && lex == LX_NUMBER) begin
        lex = LX_WS;
        finish_number(acc);
      end
      if (ph != PH_SKIP) raise_fault(ERR_TRUNC);
      parser_clear();
    end
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_taken) begin
      hold_taken <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      case (out_tuser[1:0])
        KIND_HEADER: headers_seen++;
        KIND_PIXEL: pixels_seen++;
        default: errors_seen++;
      endcase
      if (pending_results.size() == 0) begin
        $error("result of kind %0d arrived with nothing expected", out_tuser[1:0]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_kind", 16'(want.kind), 16'(out_tuser[1:0]));
        compare_field("is_colour", 16'(want.colour), 16'(out_tuser[2]));
        compare_field("image_width", want.width, out_tdata[15:0]);
        compare_field("image_height", want.height, out_tdata[31:16]);
        compare_field("pixel_value", want.pixel, out_tdata[47:32]);
        compare_field("column", want.column, out_tdata[63:48]);
        compare_field("row", want.row, out_tdata[79:64]);
        compare_field("error_code", 16'(want.err), 16'(out_tdata[82:80]));
        compare_field("last_pixel", 16'(want.last), 16'(out_tlast));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eof);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b, eof);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      push_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    file_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic void add_number(int unsigned v);
    if ($urandom_range(9) == 0) add_byte(CH_0);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic logic [7:0] non_digit(logic allow_hash);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while ((b >= CH_0 && b <= CH_9) || (!allow_hash && b == CH_HASH));
    return b;
  endfunction

  function automatic void add_noise(int unsigned n);
    repeat (n) add_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_gap(logic may_be_empty);
    logic [7:0] b;
    repeat ($urandom_range(may_be_empty ? 0 : 1, 3)) begin
      case ($urandom_range(9))
        5: add_byte(CH_LF);
        6: add_byte(CH_CR);
        7: add_byte(CH_TAB);
        8: add_byte(non_digit(1'b0));
        9: begin
          add_byte(CH_HASH);
          repeat ($urandom_range(0, 6)) begin
            do b = 8'($urandom_range(255));
            while (b == CH_LF || b == CH_CR);
            add_byte(b);
          end
          add_byte($urandom_range(1) ? CH_LF : CH_CR);
        end
        default: add_byte(CH_SPACE);
      endcase
    end
  endfunction

  function automatic logic [7:0] pick_format();
    case ($urandom_range(3))
      0: return CH_2;
      1: return CH_3;
      2: return CH_5;
      default: return CH_6;
    endcase
  endfunction

  function automatic void build_image(logic [7:0] fmt_ch, int unsigned w, int unsigned h);
    logic raw;
    int unsigned n;
    raw = (fmt_ch == CH_5 || fmt_ch == CH_6);
    n = w * h * ((fmt_ch == CH_3 || fmt_ch == CH_6) ? 3 : 1);
    add_byte(CH_P);
    add_byte(fmt_ch);
    add_gap(1'b1);
    add_number(w);
    add_gap(1'b0);
    add_number(h);
    add_gap(1'b0);
    add_number(255);
    if (raw) begin
      add_byte(non_digit(1'b1));
      add_noise(n);
    end else begin
      repeat (n) begin
        add_gap(1'b0);
        add_number(($urandom_range(19) == 0) ? $urandom_range(256, 9999) : $urandom_range(255));
      end
      if ($urandom_range(1)) add_gap(1'b0);
    end
  endfunction

  function automatic void build_random_file();
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int unsigned v;
    logic [7:0] fmt_ch;
    logic [7:0] b;
    pick = $urandom_range(99);
    fmt_ch = pick_format();
    w = ($urandom_range(19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if (pick < 77) begin
      build_image(fmt_ch, w, h);
      if (pick >= 62) begin
        repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
      end else if ($urandom_range(3) == 0) begin
        add_noise($urandom_range(1, 5));
      end
    end else if (pick < 90) begin
      case ($urandom_range(4))
        0: begin
          do b = 8'($urandom_range(255));
          while (b == CH_P);
          add_byte(b);
        end
        1: begin
          add_byte(CH_P);
          do b = 8'($urandom_range(255));
          while (b == CH_2 || b == CH_3 || b == CH_5 || b == CH_6);
          add_byte(b);
        end
        2: begin
          add_byte(CH_P);
          add_byte(fmt_ch);
          add_gap(1'b1);
          add_number($urandom_range(1) ? 0 : w);
          add_gap(1'b0);
          add_number((file_bytes[file_bytes.size() - 1] == CH_0) ? h : 0);
          add_gap(1'b0);
        end
        3: begin
          add_byte(CH_P);
          add_byte(fmt_ch);
          add_gap(1'b1);
          add_number(w);
          add_gap(1'b0);
          add_number(h);
          add_gap(1'b0);
          do v = $urandom_range(999);
          while (v == 255);
          if ($urandom_range(3) == 0) v = $urandom_range(100000, 99999999);
          add_number(v);
          add_gap(1'b0);
        end
        default: begin
          add_byte(CH_P);
          add_byte(fmt_ch);
          add_gap(1'b1);
          add_number($urandom_range(1000, 99999999));
          add_gap(1'b0);
          add_number($urandom_range(1, 99999));
          add_gap(1'b0);
          add_number(255);
          add_gap(1'b0);
        end
      endcase
      add_noise($urandom_range(0, 4));
    end else begin
      if ($urandom_range(1)) add_byte(CH_P);
      add_noise($urandom_range(1, 12));
    end
  endfunction

  task automatic test_format_faults();
    add_text("Q");
    send_file();
    add_text("P4");
    send_file();
    add_text("P50 1");
    send_file();
    add_text("P31 1 256");
    send_file();
  endtask

  task automatic test_special_cases();
    add_text("P61 1#c\n255");
    send_file();
    add_text("P21 1 255 999");
    send_file();
    add_text("P52 1 255#");
    add_byte(8'h00);
    add_byte(8'hff);
    send_file();
    add_text("P61 1 255 ");
    add_byte(8'hff);
    add_byte(8'h00);
    add_byte(8'hff);
    send_file();
    add_text("P2999999 1 255");
    send_file();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    int unsigned start;
    idle_mix = '{0, 78, 0, 9};
    stall_mix = '{0, 0, 78, 9};
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_mix[p];
      stall_pct = stall_mix[p];
      start = live_bytes;
      while (live_bytes - start < PHASE_BYTES) begin
        build_random_file();
        send_file();
      end
    end
  endtask

  task automatic test_output_hold();
    idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    build_image(CH_5, 16, 3);
    send_file();
  endtask

  initial begin
    parser_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_format_faults();
    test_special_cases();
    test_random_traffic();
    test_output_hold();
    wait_drained();
    $display("Sent %0d files (%0d parsed bytes) across four idling regimes and a long output hold.",
             files_sent, live_bytes);
    $display("Checked %0d header records, %0d pixels and %0d errors.",
             headers_seen, pixels_seen, errors_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/pnmsp_pkg.sv
hdl/pnmsp_parser.sv
hdl/pnmsp_out_fifo.sv
hdl/pnm_stream_parser_unit.sv
tb/pnm_stream_parser_unit_tb.sv
